[hw/rtl/hcg_pkg.sv]
// Shared constants, types and helpers for the horizontal color gradient core.
package hcg_pkg;

    localparam int MAX_COLUMNS = 4096;
    localparam int FRAC_BITS   = 16;
    localparam int CH_W        = 8;
    localparam int RGB_W       = 3 * CH_W;
    localparam int ACC_W       = CH_W + FRAC_BITS;
    localparam int DELTA_W     = ACC_W + 1;
    localparam int WID_W       = $clog2(MAX_COLUMNS) + 1;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int CFG_IDX_W   = 2;
    localparam int CNT_W       = $clog2(ACC_W + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_START_RGB = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_END_RGB   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_BAR_WIDTH = CFG_IDX_W'(2);

    localparam logic [RGB_W-1:0] START_RESET = '0;
    localparam logic [RGB_W-1:0] END_RESET   = '1;
    localparam logic [WID_W-1:0] WIDTH_RESET = WID_W'(1);

    typedef struct packed {
        logic             restart;
        logic [RGB_W-1:0] start_rgb;
        logic [RGB_W-1:0] end_rgb;
        logic [WID_W-1:0] width;
        logic [COL_W-1:0] col;
        logic             last;
    } t_cmd;

    typedef enum logic {
        BK_IDLE,
        BK_DIV
    } t_back_state;

    function automatic logic [WID_W-1:0] eff_width(input logic [WID_W-1:0] w);
        logic [WID_W-1:0] r;
        r = w;
        if (w == '0) begin
            r = WID_W'(1);
        end else if (w > WID_W'(MAX_COLUMNS)) begin
            r = WID_W'(MAX_COLUMNS);
        end
        return r;
    endfunction

endpackage

[hw/rtl/hcg_front.sv]
// Front end: config registers, column tracking and request classification.
module hcg_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [hcg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hcg_pkg::RGB_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_first_column,
    input  logic                            i_q_full,
    output logic                            o_q_push,
    output hcg_pkg::t_cmd                   o_q_cmd
);

    logic [hcg_pkg::RGB_W-1:0] r_start_rgb;
    logic [hcg_pkg::RGB_W-1:0] r_end_rgb;
    logic [hcg_pkg::WID_W-1:0] r_bar_width;
    logic [hcg_pkg::COL_W-1:0] r_count;
    logic [hcg_pkg::COL_W-1:0] n_count;
    logic                      r_auto;
    logic [hcg_pkg::RGB_W-1:0] r_snap_start;
    logic [hcg_pkg::RGB_W-1:0] r_snap_end;
    logic [hcg_pkg::WID_W-1:0] r_snap_width;

    logic [hcg_pkg::WID_W-1:0] w_eff;
    logic                      restart_cur;
    logic                      accept;
    logic                      cfg_wr;
    hcg_pkg::t_cmd             cmd;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign o_in_ready  = !i_q_full;
    assign accept      = i_in_valid && !i_q_full;
    assign w_eff       = hcg_pkg::eff_width(r_bar_width);
    assign restart_cur = i_first_column || ({1'b0, r_count} >= w_eff);

    always_comb begin
        cmd.restart   = restart_cur || r_auto;
        cmd.start_rgb = restart_cur ? r_start_rgb : r_snap_start;
        cmd.end_rgb   = restart_cur ? r_end_rgb : r_snap_end;
        cmd.width     = restart_cur ? w_eff : r_snap_width;
        cmd.col       = cmd.restart ? '0 : r_count;
        cmd.last      = ({1'b0, cmd.col} == (w_eff - hcg_pkg::WID_W'(1)));
        n_count       = cmd.last ? '0 : cmd.col + hcg_pkg::COL_W'(1);
    end

    assign o_q_push = accept;
    assign o_q_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_rgb <= hcg_pkg::START_RESET;
            r_end_rgb   <= hcg_pkg::END_RESET;
            r_bar_width <= hcg_pkg::WIDTH_RESET;
            r_count     <= '0;
            r_auto      <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (i_cfg_index)
                    hcg_pkg::CFG_START_RGB: r_start_rgb <= i_cfg_data;
                    hcg_pkg::CFG_END_RGB:   r_end_rgb   <= i_cfg_data;
                    hcg_pkg::CFG_BAR_WIDTH: r_bar_width <= i_cfg_data[hcg_pkg::WID_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_count <= n_count;
                r_auto  <= cmd.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && cmd.last) begin
            r_snap_start <= r_start_rgb;
            r_snap_end   <= r_end_rgb;
            r_snap_width <= w_eff;
        end
    end

endmodule

[hw/rtl/hcg_queue.sv]
// Two-entry request queue between front and back end.
module hcg_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hcg_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output hcg_pkg::t_cmd o_cmd
);

    hcg_pkg::t_cmd r_mem [2];
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

[hw/rtl/hcg_div.sv]
// Radix-2 restoring divider for one channel step: ((e - s) << FRAC_BITS) / w.
module hcg_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [hcg_pkg::CH_W-1:0]      i_s,
    input  logic [hcg_pkg::CH_W-1:0]      i_e,
    input  logic [hcg_pkg::WID_W-1:0]     i_w,
    output logic                          o_done,
    output logic [hcg_pkg::DELTA_W-1:0]   o_delta
);

    logic                          r_busy;
    logic                          r_done;
    logic [hcg_pkg::CNT_W-1:0]     r_cnt;
    logic [hcg_pkg::WID_W-2:0]     r_rem;
    logic [hcg_pkg::ACC_W-1:0]     r_quo;
    logic                          r_neg;
    logic [hcg_pkg::WID_W-1:0]     r_w;

    logic                          neg;
    logic [hcg_pkg::CH_W-1:0]      mag;
    logic [hcg_pkg::WID_W-1:0]     trial;
    logic                          ge;
    logic [hcg_pkg::WID_W-1:0]     diff;

    assign neg   = (i_e < i_s);
    assign mag   = neg ? (i_s - i_e) : (i_e - i_s);
    assign trial = {r_rem, r_quo[hcg_pkg::ACC_W-1]};
    assign ge    = (trial >= r_w);
    assign diff  = trial - r_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == hcg_pkg::CNT_W'(hcg_pkg::ACC_W - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= {mag, {hcg_pkg::FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_cnt <= '0;
            r_neg <= neg;
            r_w   <= i_w;
        end else if (r_busy) begin
            r_rem <= ge ? diff[hcg_pkg::WID_W-2:0] : trial[hcg_pkg::WID_W-2:0];
            r_quo <= {r_quo[hcg_pkg::ACC_W-2:0], ge};
            r_cnt <= r_cnt + hcg_pkg::CNT_W'(1);
        end
    end

    assign o_done  = r_done;
    assign o_delta = r_neg ? (hcg_pkg::DELTA_W'(0) - {1'b0, r_quo}) : {1'b0, r_quo};

endmodule

[hw/rtl/hcg_back.sv]
// Back end: accumulators, step dividers and the output register.
module hcg_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  hcg_pkg::t_cmd                 i_q_cmd,
    output logic                          o_q_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [hcg_pkg::RGB_W-1:0]     o_pixel_rgb,
    output logic [hcg_pkg::COL_W-1:0]     o_column_index,
    output logic                          o_last_column
);

    localparam int CH = hcg_pkg::CH_W;
    localparam int AW = hcg_pkg::ACC_W;
    localparam int FB = hcg_pkg::FRAC_BITS;

    hcg_pkg::t_back_state r_state;
    hcg_pkg::t_back_state n_state;

    logic [AW-1:0]                 r_acc_r, r_acc_g, r_acc_b;
    logic [hcg_pkg::DELTA_W-1:0]   r_dl_r, r_dl_g, r_dl_b;
    logic [hcg_pkg::COL_W-1:0]     r_col;
    logic                          r_last;
    logic                          r_out_valid;
    logic [hcg_pkg::RGB_W-1:0]     r_pixel;
    logic [hcg_pkg::COL_W-1:0]     r_out_col;
    logic                          r_out_last;

    logic                          out_free;
    logic                          pop;
    logic                          div_start;
    logic                          emit_adv;
    logic                          emit_div;
    logic                          div_done;
    logic                          done_r, done_g, done_b;
    logic [hcg_pkg::DELTA_W-1:0]   q_r, q_g, q_b;
    logic [hcg_pkg::DELTA_W-1:0]   dl_r, dl_g, dl_b;

    assign out_free = !r_out_valid || i_out_ready;
    assign div_done = done_r && done_g && done_b;

    hcg_div u_div_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_s     (i_q_cmd.start_rgb[3*CH-1:2*CH]),
        .i_e     (i_q_cmd.end_rgb[3*CH-1:2*CH]),
        .i_w     (i_q_cmd.width),
        .o_done  (done_r),
        .o_delta (q_r)
    );

    hcg_div u_div_g (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_s     (i_q_cmd.start_rgb[2*CH-1:CH]),
        .i_e     (i_q_cmd.end_rgb[2*CH-1:CH]),
        .i_w     (i_q_cmd.width),
        .o_done  (done_g),
        .o_delta (q_g)
    );

    hcg_div u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_s     (i_q_cmd.start_rgb[CH-1:0]),
        .i_e     (i_q_cmd.end_rgb[CH-1:0]),
        .i_w     (i_q_cmd.width),
        .o_done  (done_b),
        .o_delta (q_b)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hcg_pkg::BK_IDLE: begin
                if (!i_q_empty && out_free && i_q_cmd.restart) begin
                    n_state = hcg_pkg::BK_DIV;
                end
            end
            hcg_pkg::BK_DIV: begin
                if (div_done) begin
                    n_state = hcg_pkg::BK_IDLE;
                end
            end
            default: n_state = hcg_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        pop       = 1'b0;
        div_start = 1'b0;
        emit_adv  = 1'b0;
        emit_div  = 1'b0;
        unique case (r_state)
            hcg_pkg::BK_IDLE: begin
                pop       = !i_q_empty && out_free;
                div_start = pop && i_q_cmd.restart;
                emit_adv  = pop && !i_q_cmd.restart;
            end
            hcg_pkg::BK_DIV: begin
                emit_div = div_done;
            end
            default: ;
        endcase
    end

    assign dl_r = emit_div ? q_r : r_dl_r;
    assign dl_g = emit_div ? q_g : r_dl_g;
    assign dl_b = emit_div ? q_b : r_dl_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hcg_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
            r_acc_r     <= '0;
            r_acc_g     <= '0;
            r_acc_b     <= '0;
            r_dl_r      <= '0;
            r_dl_g      <= '0;
            r_dl_b      <= '0;
        end else begin
            r_state <= n_state;
            if (emit_adv || emit_div) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (div_start) begin
                r_acc_r <= {i_q_cmd.start_rgb[3*CH-1:2*CH], {FB{1'b0}}};
                r_acc_g <= {i_q_cmd.start_rgb[2*CH-1:CH], {FB{1'b0}}};
                r_acc_b <= {i_q_cmd.start_rgb[CH-1:0], {FB{1'b0}}};
            end else if (emit_adv || emit_div) begin
                r_acc_r <= r_acc_r + dl_r[AW-1:0];
                r_acc_g <= r_acc_g + dl_g[AW-1:0];
                r_acc_b <= r_acc_b + dl_b[AW-1:0];
            end
            if (emit_div) begin
                r_dl_r <= q_r;
                r_dl_g <= q_g;
                r_dl_b <= q_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_col  <= i_q_cmd.col;
            r_last <= i_q_cmd.last;
        end
        if (emit_adv || emit_div) begin
            r_pixel <= {r_acc_r[AW-1:FB], r_acc_g[AW-1:FB], r_acc_b[AW-1:FB]};
        end
        if (emit_adv) begin
            r_out_col  <= i_q_cmd.col;
            r_out_last <= i_q_cmd.last;
        end else if (emit_div) begin
            r_out_col  <= r_col;
            r_out_last <= r_last;
        end
    end

    assign o_q_pop        = pop;
    assign o_out_valid    = r_out_valid;
    assign o_pixel_rgb    = r_pixel;
    assign o_column_index = r_out_col;
    assign o_last_column  = r_out_last;

endmodule

[hw/rtl/horizontal_color_gradient_core.sv]
// Horizontal RGB888 gradient generator: top level.
// An advancing column passes the request queue and the output register; a restart
// (first column, width overrun or the column after the last) also waits for
// the 24-step radix-2 step dividers that run for all three channels.
// Throughput: one column per cycle between restarts, while i_out_ready does not stall the output.
// Reset: synchronous active low; registers return to start 0, end 0xffffff, width 1.
module horizontal_color_gradient_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [hcg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hcg_pkg::RGB_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_first_column,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [hcg_pkg::RGB_W-1:0]       o_pixel_rgb,
    output logic [hcg_pkg::COL_W-1:0]       o_column_index,
    output logic                            o_last_column
);

    logic          q_full;
    logic          q_empty;
    logic          q_push;
    logic          q_pop;
    hcg_pkg::t_cmd q_wr_cmd;
    hcg_pkg::t_cmd q_rd_cmd;

    hcg_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_first_column (i_first_column),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_cmd        (q_wr_cmd)
    );

    hcg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_wr_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_rd_cmd)
    );

    hcg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_cmd        (q_rd_cmd),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_rgb    (o_pixel_rgb),
        .o_column_index (o_column_index),
        .o_last_column  (o_last_column)
    );

endmodule

[hw/rtl/hcg_checker.sv]
// Port-level checker for the gradient core, bound to the top level.
module hcg_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_ready,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  logic [hcg_pkg::RGB_W-1:0]       o_pixel_rgb,
    input  logic [hcg_pkg::COL_W-1:0]       o_column_index,
    input  logic                            o_last_column
);

    logic [3:0] r_pending;
    logic       r_after_last;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending    <= '0;
            r_after_last <= 1'b0;
        end else begin
            r_pending <= r_pending + 4'(in_acc) - 4'(out_acc);
            if (out_acc) begin
                r_after_last <= o_last_column;
            end
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pixel_rgb)
            && $stable(o_column_index) && $stable(o_last_column))
        else $error("stalled result changed");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != 4'd0)
        else $error("result without an outstanding request");

    a_bar_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_after_last |-> o_column_index == '0)
        else $error("column after the last one is not column zero");

endmodule

bind horizontal_color_gradient_core hcg_checker u_hcg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_pixel_rgb    (o_pixel_rgb),
    .o_column_index (o_column_index),
    .o_last_column  (o_last_column)
);
